// ===== sv/cobs_rw_pkg.sv =====
// ----------------------------------------------------------------------------
// COBS ring writer package
// Shared codes and default sizes for the COBS ring writer.
// ----------------------------------------------------------------------------
`default_nettype none

package cobs_rw_pkg;

  localparam int OP_W         = 2;
  localparam int BYTE_W       = 8;
  localparam int MAX_RING_DEF = 4096;
  localparam int RING_RESET   = 1024;
  localparam int RING_MIN     = 2;
  localparam int MAX_RUN      = 255;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic {
    KIND_WRITE   = 1'b0,
    KIND_PUBLISH = 1'b1
  } kind_t;

endpackage

`default_nettype wire

// ===== sv/cobs_ring_writer_core.sv =====
// ----------------------------------------------------------------------------
// COBS ring writer core
// Encodes frames with COBS straight into a circular buffer, emitting byte
// writes as address/data pairs, back-patched code bytes and pointer publishes.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register and moves on into the result
// register once that register is free. Throughput: one item per cycle while each
// item makes one result, the output is not stalled and no reduction runs; an
// item making two or three results holds the input until the results drain.
// Reset clears both positions, closes the frame and sets the ring to 1024 bytes.
// A ring size write re-reduces both positions with input blocked.
`default_nettype none

module cobs_ring_writer_core #(
  parameter int MAX_RING = cobs_rw_pkg::MAX_RING_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [$clog2(MAX_RING):0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [cobs_rw_pkg::OP_W-1:0]      in_operation,
  input  wire logic [cobs_rw_pkg::BYTE_W-1:0]    in_data_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic [$clog2(MAX_RING)-1:0]            out_wr_addr,
  output logic [cobs_rw_pkg::BYTE_W-1:0]         out_wr_data,
  output logic                                   out_last
);

  import cobs_rw_pkg::*;

  localparam int PosW  = $clog2(MAX_RING);
  localparam int SizeW = PosW + 1;
  localparam int CntW  = $clog2(PosW + 1);
  localparam logic [SizeW-1:0] SizeMax   = SizeW'(MAX_RING);
  localparam logic [SizeW-1:0] SizeMin   = SizeW'(RING_MIN);
  localparam logic [SizeW-1:0] SizeReset =
    (RING_RESET > MAX_RING) ? SizeW'(MAX_RING) : SizeW'(RING_RESET);
  localparam logic [SizeW-1:0] RunMax    = SizeW'(MAX_RUN);

  typedef struct packed {
    logic              kind;
    logic [PosW-1:0]   addr;
    logic [BYTE_W-1:0] data;
    logic              last;
  } res_t;

  function automatic logic [PosW-1:0] advance(input logic [PosW-1:0] p,
                                              input logic [SizeW-1:0] s);
    logic [SizeW-1:0] n;
    n = {1'b0, p} + SizeW'(1);
    return (n >= s) ? '0 : n[PosW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] distance(input logic [PosW-1:0] w,
                                                input logic [PosW-1:0] m,
                                                input logic [SizeW-1:0] s);
    logic [SizeW-1:0] d;
    if (w >= m) begin
      d = {1'b0, w} - {1'b0, m};
    end else begin
      d = {1'b0, w} + s - {1'b0, m};
    end
    return d;
  endfunction

  // Architectural state.
  logic [SizeW-1:0] size_r;
  logic [PosW-1:0]  wpos_r, wpos_nxt;
  logic [PosW-1:0]  mark_r, mark_nxt;
  logic             open_r, open_nxt;

  // Input register.
  logic              s1_valid_r;
  logic [OP_W-1:0]   s1_op_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register.
  res_t       res_r [3];
  res_t       res_nxt [3];
  res_t       res_new [3];
  logic [1:0] cnt_r, cnt_nxt, cnt_new;

  // Position reduction after a ring size write.
  logic             busy_r, pend_r;
  logic [CntW-1:0]  red_cnt_r;
  logic [SizeW-1:0] div_r;
  logic [PosW-1:0]  src_w_r, src_m_r;
  logic [SizeW-1:0] rem_w_r, rem_m_r;
  logic [SizeW-1:0] rem_w_sh, rem_m_sh, rem_w_nxt, rem_m_nxt;
  logic             red_done;
  logic [SizeW-1:0] cfg_size;

  logic in_xfer, out_xfer, s2_free, s1_fire;
  logic [PosW-1:0]  w1, w2;
  logic [SizeW-1:0] d0, d1;

  assign cfg_size = (cfg_wdata < SizeMin) ? SizeMin :
                    (cfg_wdata > SizeMax) ? SizeMax : cfg_wdata;

  assign out_valid   = (cnt_r != 2'd0);
  assign out_kind    = res_r[0].kind;
  assign out_wr_addr = res_r[0].addr;
  assign out_wr_data = res_r[0].data;
  assign out_last    = res_r[0].last;

  assign out_xfer = out_valid && out_ready;
  assign s2_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_ready = !busy_r && (!s1_valid_r || s1_fire);
  assign in_xfer  = in_valid && in_ready;

  assign w1 = advance(wpos_r, size_r);
  assign w2 = advance(w1, size_r);
  assign d0 = distance(wpos_r, mark_r, size_r);
  assign d1 = distance(w1, mark_r, size_r);

  always_comb begin
    wpos_nxt = wpos_r;
    mark_nxt = mark_r;
    open_nxt = open_r;
    cnt_new  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res_new[i] = '{kind: KIND_WRITE, addr: '0, data: '0, last: 1'b0};
    end
    unique case (op_t'(s1_op_r))
      OP_OPEN: begin
        if (!open_r) begin
          res_new[0] = '{kind: KIND_WRITE, addr: wpos_r, data: '0, last: 1'b1};
          cnt_new  = 2'd1;
          mark_nxt = wpos_r;
          wpos_nxt = w1;
          open_nxt = 1'b1;
        end
      end
      OP_DATA: begin
        if (open_r) begin
          if (s1_byte_r == '0) begin
            res_new[0] = '{kind: KIND_WRITE, addr: mark_r, data: d0[BYTE_W-1:0],
                           last: 1'b0};
            res_new[1] = '{kind: KIND_WRITE, addr: wpos_r, data: '0, last: 1'b1};
            cnt_new  = 2'd2;
            mark_nxt = wpos_r;
            wpos_nxt = w1;
          end else if (d1 == RunMax) begin
            res_new[0] = '{kind: KIND_WRITE, addr: wpos_r, data: s1_byte_r,
                           last: 1'b0};
            res_new[1] = '{kind: KIND_WRITE, addr: mark_r, data: d1[BYTE_W-1:0],
                           last: 1'b0};
            res_new[2] = '{kind: KIND_WRITE, addr: w1, data: '0, last: 1'b1};
            cnt_new  = 2'd3;
            mark_nxt = w1;
            wpos_nxt = w2;
          end else begin
            res_new[0] = '{kind: KIND_WRITE, addr: wpos_r, data: s1_byte_r,
                           last: 1'b1};
            cnt_new  = 2'd1;
            wpos_nxt = w1;
          end
        end
      end
      OP_CLOSE: begin
        if (open_r) begin
          res_new[0] = '{kind: KIND_WRITE, addr: mark_r, data: d0[BYTE_W-1:0],
                         last: 1'b0};
          res_new[1] = '{kind: KIND_WRITE, addr: wpos_r, data: '0, last: 1'b0};
          res_new[2] = '{kind: KIND_PUBLISH, addr: w1, data: '0, last: 1'b1};
          cnt_new  = 2'd3;
          mark_nxt = wpos_r;
          wpos_nxt = w1;
          open_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = res_r[i];
    end
    if (s1_fire) begin
      cnt_nxt = cnt_new;
      for (int i = 0; i < 3; i++) begin
        res_nxt[i] = res_new[i];
      end
    end else if (out_xfer) begin
      cnt_nxt    = cnt_r - 2'd1;
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
    end
  end

  assign rem_w_sh  = {rem_w_r[SizeW-2:0], src_w_r[PosW-1]};
  assign rem_m_sh  = {rem_m_r[SizeW-2:0], src_m_r[PosW-1]};
  assign rem_w_nxt = (rem_w_sh >= div_r) ? rem_w_sh - div_r : rem_w_sh;
  assign rem_m_nxt = (rem_m_sh >= div_r) ? rem_m_sh - div_r : rem_m_sh;
  assign red_done  = busy_r && (red_cnt_r == CntW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= SizeReset;
      wpos_r     <= '0;
      mark_r     <= '0;
      open_r     <= 1'b0;
      s1_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
      busy_r     <= 1'b0;
      pend_r     <= 1'b0;
      red_cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (red_done) begin
        wpos_r <= rem_w_nxt[PosW-1:0];
        mark_r <= rem_m_nxt[PosW-1:0];
      end else if (s1_fire) begin
        wpos_r <= wpos_nxt;
        mark_r <= mark_nxt;
      end
      if (s1_fire) begin
        open_r <= open_nxt;
      end
      if (cfg_we) begin
        size_r <= cfg_size;
      end
      if (busy_r) begin
        if (red_done) begin
          if (pend_r || cfg_we) begin
            red_cnt_r <= CntW'(PosW);
            pend_r    <= 1'b0;
          end else begin
            red_cnt_r <= red_cnt_r - CntW'(1);
            busy_r    <= 1'b0;
          end
        end else begin
          red_cnt_r <= red_cnt_r - CntW'(1);
          if (cfg_we) begin
            pend_r <= 1'b1;
          end
        end
      end else if (cfg_we) begin
        busy_r    <= 1'b1;
        red_cnt_r <= CntW'(PosW);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_data_byte;
    end
    for (int i = 0; i < 3; i++) begin
      res_r[i] <= res_nxt[i];
    end
    if (busy_r && !red_done) begin
      src_w_r <= {src_w_r[PosW-2:0], 1'b0};
      src_m_r <= {src_m_r[PosW-2:0], 1'b0};
      rem_w_r <= rem_w_nxt;
      rem_m_r <= rem_m_nxt;
    end else if (red_done || cfg_we) begin
      src_w_r <= red_done ? rem_w_nxt[PosW-1:0] : wpos_r;
      src_m_r <= red_done ? rem_m_nxt[PosW-1:0] : mark_r;
      rem_w_r <= '0;
      rem_m_r <= '0;
      div_r   <= (red_done && !cfg_we) ? size_r : cfg_size;
    end
  end

  a_busy_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready)
    else $error("input taken during position reduction");

  a_wpos_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ({1'b0, wpos_r} < size_r))
    else $error("write position outside ring");

  a_mark_in_ring : assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> ({1'b0, mark_r} < size_r))
    else $error("marker position outside ring");

  a_publish_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PUBLISH) |-> (out_last && out_wr_data == '0))
    else $error("publish transfer not final or carries data");

endmodule

`default_nettype wire
